// File: rtl/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the timed event queue
// Table geometry, entry layout, key function, result codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	localparam int TIME_BITS   = 6;
	// 63*3600 + 63*60 + 63 fits in 18 bits
	localparam int KEY_BITS    = 18;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_NEXT = 1'b1;

	typedef logic [ID_BITS-1:0]   id_t;
	typedef logic [TIME_BITS-1:0] tpart_t;
	typedef logic [KEY_BITS-1:0]  key_t;

	typedef struct packed {
		id_t    id;
		tpart_t hours;
		tpart_t minutes;
		tpart_t seconds;
	} evt_t;

	typedef enum logic [1:0] {
		ST_ADDED = 2'd0,
		ST_TAKEN = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_SETTLE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;    // latch input word
		logic scan_start; // clear scan index and best candidate
		logic scan_issue; // read one entry into the key stage
		logic commit;     // update table and load result register
	} cmd_t;

	typedef struct packed {
		logic func_next;
		logic empty;
		logic scan_last;
		logic out_free;
	} stat_t;

	function automatic key_t key_of(input evt_t e);
		key_of = KEY_BITS'(e.hours) * KEY_BITS'(3600)
		       + KEY_BITS'(e.minutes) * KEY_BITS'(60)
		       + KEY_BITS'(e.seconds);
	endfunction

endpackage

// File: rtl/teq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ctrl: sequencing for the timed event queue
// Accepts a word, runs the table scan for take requests, and commits
// once the result register is free.
// ----------------------------------------------------------------------------
module teq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  teq_pkg::stat_t stat,
	output teq_pkg::cmd_t  cmd
);

	teq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= teq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			teq_pkg::S_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = teq_pkg::S_DECIDE;
				end
			end
			teq_pkg::S_DECIDE: begin
				if (stat.func_next && !stat.empty) begin
					cmd.scan_start = 1'b1;
					state_d        = teq_pkg::S_SCAN;
				end else begin
					state_d = teq_pkg::S_FINISH;
				end
			end
			teq_pkg::S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = teq_pkg::S_SETTLE;
				end
			end
			teq_pkg::S_SETTLE: begin
				state_d = teq_pkg::S_FINISH;
			end
			teq_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = teq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = teq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/teq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_dp: event table, min-key scan pipe and result register
// Scan reads one entry per cycle, forms its key in a stage, then
// compares against the running best. Removal shifts the tail down.
// ----------------------------------------------------------------------------
module teq_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  teq_pkg::cmd_t                  cmd,
	output teq_pkg::stat_t                 stat,
	input  logic                           func,
	input  logic [7:0]                     event_id,
	input  logic [teq_pkg::TIME_BITS-1:0]  event_hours,
	input  logic [teq_pkg::TIME_BITS-1:0]  event_minutes,
	input  logic [teq_pkg::TIME_BITS-1:0]  event_seconds,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [7:0]                     out_id,
	output logic [teq_pkg::TIME_BITS-1:0]  out_hours,
	output logic [teq_pkg::TIME_BITS-1:0]  out_minutes,
	output logic [teq_pkg::TIME_BITS-1:0]  out_seconds
);

	logic                           func_q;
	teq_pkg::evt_t                  in_evt_q;
	teq_pkg::evt_t                  tbl_q [teq_pkg::TABLE_DEPTH];
	logic [teq_pkg::CNT_BITS-1:0]   count_q;
	logic [teq_pkg::IDX_BITS-1:0]   scan_idx_q;

	logic                           kv_s1;
	teq_pkg::key_t                  key_s1;
	teq_pkg::evt_t                  evt_s1;
	logic [teq_pkg::IDX_BITS-1:0]   idx_s1;

	logic                           best_valid_q;
	teq_pkg::key_t                  best_key_q;
	teq_pkg::evt_t                  best_evt_q;
	logic [teq_pkg::IDX_BITS-1:0]   best_idx_q;

	logic                           out_valid_q;
	teq_pkg::status_t               status_q;
	teq_pkg::evt_t                  out_evt_q;

	logic                           full;
	logic                           empty;
	logic                           do_add;
	logic                           do_take;

	assign full    = (count_q == teq_pkg::CNT_BITS'(teq_pkg::TABLE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_add  = cmd.commit && (func_q == teq_pkg::FUNC_ADD) && !full;
	assign do_take = cmd.commit && (func_q == teq_pkg::FUNC_NEXT) && !empty;

	assign stat.func_next = (func_q == teq_pkg::FUNC_NEXT);
	assign stat.empty     = empty;
	assign stat.scan_last = ((teq_pkg::CNT_BITS'(scan_idx_q) + teq_pkg::CNT_BITS'(1))
	                         == count_q);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q           <= func;
			in_evt_q.id      <= teq_pkg::id_t'(event_id);
			in_evt_q.hours   <= event_hours;
			in_evt_q.minutes <= event_minutes;
			in_evt_q.seconds <= event_seconds;
		end
	end

	// table storage: append at count, close the gap on removal
	always_ff @(posedge clk) begin
		if (do_add) begin
			tbl_q[count_q[teq_pkg::IDX_BITS-1:0]] <= in_evt_q;
		end
		if (do_take) begin
			for (int i = 0; i < teq_pkg::TABLE_DEPTH - 1; i++) begin
				if (teq_pkg::IDX_BITS'(i) >= best_idx_q) begin
					tbl_q[i] <= tbl_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_add) begin
			count_q <= count_q + teq_pkg::CNT_BITS'(1);
		end else if (do_take) begin
			count_q <= count_q - teq_pkg::CNT_BITS'(1);
		end
	end

	// scan: read stage and key stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			kv_s1      <= 1'b0;
		end else begin
			kv_s1 <= cmd.scan_issue;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_idx_q <= scan_idx_q + teq_pkg::IDX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			evt_s1 <= tbl_q[scan_idx_q];
			key_s1 <= teq_pkg::key_of(tbl_q[scan_idx_q]);
			idx_s1 <= scan_idx_q;
		end
	end

	// running minimum; strict less keeps the earliest entry on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (cmd.scan_start) begin
			best_valid_q <= 1'b0;
		end else if (kv_s1) begin
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (kv_s1 && (!best_valid_q || (key_s1 < best_key_q))) begin
			best_key_q <= key_s1;
			best_evt_q <= evt_s1;
			best_idx_q <= idx_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_evt_q <= '0;
			if (func_q == teq_pkg::FUNC_ADD) begin
				status_q <= full ? teq_pkg::ST_FULL : teq_pkg::ST_ADDED;
			end else if (empty) begin
				status_q <= teq_pkg::ST_EMPTY;
			end else begin
				status_q  <= teq_pkg::ST_TAKEN;
				out_evt_q <= best_evt_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_id      = 8'(out_evt_q.id);
	assign out_hours   = out_evt_q.hours;
	assign out_minutes = out_evt_q.minutes;
	assign out_seconds = out_evt_q.seconds;

endmodule

// File: rtl/timed_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_core: earliest-first table of timed events
// Holds up to 16 events (id plus h:m:s); serves the one with the
// smallest h*3600+m*60+s, earliest added on ties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per request:
//   func selects add (store event) or next (take earliest event).
//   Output channel (out_valid/out_stall) returns exactly one word per
//   request: status plus the taken event, fields zero unless taken.
// Sequencing:
//   add, or next on an empty table: accept, decide, then commit in the
//   finish state. next on a table of n entries: accept, decide, scan the
//   n entries one per cycle through a single key/compare unit, settle,
//   then commit; the removal shift of the table tail is done in parallel
//   at commit. One request is in flight at a time; the next word is
//   accepted the cycle after the previous result is loaded into the output
//   register, even if that result is still waiting to be taken.
// Reset:
//   arst_n empties the table and drops any pending result word.
// Stall:
//   While out_stall is high the result word holds; a finished request
//   waits in its last state until the output register frees up.
// ----------------------------------------------------------------------------
module timed_event_queue_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] event_id,
	input  logic [5:0] event_hours,
	input  logic [5:0] event_minutes,
	input  logic [5:0] event_seconds,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] out_id,
	output logic [5:0] out_hours,
	output logic [5:0] out_minutes,
	output logic [5:0] out_seconds
);

	teq_pkg::cmd_t  cmd;
	teq_pkg::stat_t stat;

	teq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	teq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.event_id      (event_id),
		.event_hours   (event_hours),
		.event_minutes (event_minutes),
		.event_seconds (event_seconds),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.out_id        (out_id),
		.out_hours     (out_hours),
		.out_minutes   (out_minutes),
		.out_seconds   (out_seconds)
	);

endmodule
